// ----- rtl/nibble_mask_byte_classifier_top_assert.svh -----
// Assertion macros shared by the checker.
`ifndef NIBBLE_MASK_BYTE_CLASSIFIER_TOP_ASSERT_SVH
`define NIBBLE_MASK_BYTE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define NMBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nmbc check failed");

// Next-cycle implication, disabled in reset.
`define NMBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nmbc check failed");

`endif

// ----- rtl/nmbc_pkg.sv -----
package nmbc_pkg;

    localparam int MASK_BITS_DEF = 8;
    localparam int NIBBLES       = 16;
    localparam int NIB_W         = 4;

    localparam logic [1:0] FN_CLEAR    = 2'd0;
    localparam logic [1:0] FN_ADD_ROW  = 2'd1;
    localparam logic [1:0] FN_ADD_BYTE = 2'd2;
    localparam logic [1:0] FN_CLASSIFY = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- rtl/nmbc_in_if.sv -----
interface nmbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [7:0]  byte_value;

    modport source (output valid, func, row_index, row_bits, byte_value, input ready);
    modport sink (input valid, func, row_index, row_bits, byte_value, output ready);
endinterface

// ----- rtl/nmbc_out_if.sv -----
interface nmbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] match_mask;
    logic [3:0] bits_used;
    logic       overflow;

    modport source (output valid, match_mask, bits_used, overflow, input ready);
    modport sink (input valid, match_mask, bits_used, overflow, output ready);
endinterface

// ----- rtl/nmbc_ctrl.sv -----
module nmbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output nmbc_pkg::t_dp_cmd o_cmd
);
    import nmbc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_ready;

    assign in_ready    = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = i_in_valid && in_ready;
    assign o_cmd.exec  = (r_state == ST_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == ST_EXEC) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ----- rtl/nmbc_datapath.sv -----
module nmbc_datapath #(
    parameter int MASK_BITS = nmbc_pkg::MASK_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nmbc_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]        i_func,
    input  logic [3:0]        i_row_index,
    input  logic [15:0]       i_row_bits,
    input  logic [7:0]        i_byte_value,
    output logic [7:0]        o_match_mask,
    output logic [3:0]        o_bits_used,
    output logic              o_overflow
);
    import nmbc_pkg::*;

    localparam int CW = $clog2(MASK_BITS + 1);

    logic [1:0]           r_func;
    logic [NIB_W-1:0]     r_row_index;
    logic [15:0]          r_row_bits;
    logic [7:0]           r_byte;

    logic [MASK_BITS-1:0] r_low  [NIBBLES];
    logic [MASK_BITS-1:0] r_high [NIBBLES];
    logic [15:0]          r_seen [MASK_BITS];
    logic [MASK_BITS-1:0] r_valid;
    logic [CW-1:0]        r_used, n_used;

    logic [7:0]           r_match;
    logic [3:0]           r_bits_used;
    logic                 r_ovf;

    logic [MASK_BITS-1:0] hit_vec, hit_bit, new_bit, seen_we;
    logic [MASK_BITS-1:0] low_set  [NIBBLES];
    logic [MASK_BITS-1:0] high_set [NIBBLES];
    logic [MASK_BITS-1:0] match_full;
    logic [MASK_BITS+7:0] match_ext;
    logic [CW+3:0]        used_ext;
    logic                 full, inc, ovf, do_clear;

    always_comb begin
        for (int k = 0; k < MASK_BITS; k++) begin
            hit_vec[k] = r_valid[k] && (r_seen[k] == r_row_bits);
        end
    end

    assign hit_bit = hit_vec & (~hit_vec + MASK_BITS'(1));
    assign new_bit = MASK_BITS'(1) << r_used;
    assign full    = (r_used == CW'(MASK_BITS));

    always_comb begin
        for (int j = 0; j < NIBBLES; j++) begin
            low_set[j]  = '0;
            high_set[j] = '0;
        end
        seen_we    = '0;
        match_full = '0;
        inc        = 1'b0;
        ovf        = 1'b0;
        do_clear   = 1'b0;
        case (r_func)
            FN_CLEAR: begin
                do_clear = 1'b1;
            end
            FN_ADD_ROW: begin
                if (r_row_bits != '0) begin
                    if (|hit_vec) begin
                        high_set[r_row_index] = hit_bit;
                    end else if (full) begin
                        ovf = 1'b1;
                    end else begin
                        high_set[r_row_index] = new_bit;
                        for (int j = 0; j < NIBBLES; j++) begin
                            low_set[j] = r_row_bits[j] ? new_bit : '0;
                        end
                        seen_we = new_bit;
                        inc     = 1'b1;
                    end
                end
            end
            FN_ADD_BYTE: begin
                if (full) begin
                    ovf = 1'b1;
                end else begin
                    high_set[r_byte[7:4]] = new_bit;
                    low_set[r_byte[3:0]]  = new_bit;
                    inc = 1'b1;
                end
            end
            default: begin
                match_full = r_low[r_byte[3:0]] & r_high[r_byte[7:4]];
            end
        endcase
    end

    assign n_used    = do_clear ? '0 : r_used + CW'(inc);
    assign match_ext = {8'b0, match_full};
    assign used_ext  = {4'b0, n_used};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_row_index <= i_row_index;
            r_row_bits  <= i_row_bits;
            r_byte      <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NIBBLES; j++) begin
                r_low[j]  <= '0;
                r_high[j] <= '0;
            end
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_cmd.exec) begin
            for (int j = 0; j < NIBBLES; j++) begin
                r_low[j]  <= do_clear ? '0 : (r_low[j] | low_set[j]);
                r_high[j] <= do_clear ? '0 : (r_high[j] | high_set[j]);
            end
            r_valid <= do_clear ? '0 : (r_valid | seen_we);
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int k = 0; k < MASK_BITS; k++) begin
                if (seen_we[k]) begin
                    r_seen[k] <= r_row_bits;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_match     <= match_ext[7:0];
            r_bits_used <= used_ext[3:0];
            r_ovf       <= ovf;
        end
    end

    assign o_match_mask = r_match;
    assign o_bits_used  = r_bits_used;
    assign o_overflow   = r_ovf;
endmodule

// ----- rtl/nibble_mask_byte_classifier_top.sv -----
// Nibble-mask byte classifier.
// Input channel i_in carries one command beat: clear, add class row, add
// literal byte or classify byte. Output channel o_out returns exactly one
// beat per command: match mask (classify only), bits in use, overflow flag.
// A beat is registered when it is accepted and executed in the next cycle,
// and its result is registered in the output register as it executes.
// No new beat is taken while one executes; the execute cycle does the pattern
// compare against all stored rows and the table update in one step.
// Reset clears both nibble tables, the row valid bits and the bit counter;
// the stored row patterns are left as they are and are never read unmarked.
// Reset needs no separate clearing pass, so i_in.ready may rise right after reset.
// When the receiver stalls, the result beat is held unchanged in the output
// register and no new input beat is taken until it has been accepted.
// MASK_BITS sets the number of class bits (1 to 32); match_mask shows the
// low eight of them and bits_used the low four bits of the count.
module nibble_mask_byte_classifier_top #(
    parameter int MASK_BITS = nmbc_pkg::MASK_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nmbc_in_if.sink      i_in,
    nmbc_out_if.source   o_out
);
    import nmbc_pkg::*;

    t_dp_cmd cmd;

    nmbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    nmbc_datapath #(
        .MASK_BITS (MASK_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_in.func),
        .i_row_index  (i_in.row_index),
        .i_row_bits   (i_in.row_bits),
        .i_byte_value (i_in.byte_value),
        .o_match_mask (o_out.match_mask),
        .o_bits_used  (o_out.bits_used),
        .o_overflow   (o_out.overflow)
    );
endmodule

// ----- rtl/nmbc_checker.sv -----
`include "nibble_mask_byte_classifier_top_assert.svh"

module nmbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_match_mask,
    input logic [3:0] i_bits_used,
    input logic       i_overflow
);
    logic        in_beat;
    logic        out_stall;
    logic [12:0] out_data;

    assign in_beat   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_data  = {i_match_mask, i_bits_used, i_overflow};

    `NMBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `NMBC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(out_data))
    `NMBC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_beat, !i_in_ready && !i_out_valid)
    `NMBC_ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, out_stall, !i_in_ready)
    `NMBC_ASSERT_NOW(a_ovf_no_match, i_clk, i_rst_n, i_out_valid && i_overflow, i_match_mask == 8'd0)
endmodule

bind nibble_mask_byte_classifier_top nmbc_checker u_nmbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_match_mask (o_out.match_mask),
    .i_bits_used  (o_out.bits_used),
    .i_overflow   (o_out.overflow)
);
